// File: sv/rvx_pkg.sv
// rvx_pkg: shared types, opcodes and fault codes for the RV32I executor.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rvx_pkg;

    localparam int DMEM_BYTES_DEF = 65536;

    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] OPC_FENCE  = 7'b0001111;
    localparam logic [6:0] OPC_SYSTEM = 7'b1110011;
    localparam logic [6:0] F7_ALT     = 7'b0100000;

    localparam logic [2:0] FAULT_OK     = 3'd0;
    localparam logic [2:0] FAULT_ILL    = 3'd1;
    localparam logic [2:0] FAULT_ALIGN  = 3'd2;
    localparam logic [2:0] FAULT_WINDOW = 3'd3;
    localparam logic [2:0] FAULT_SYS    = 3'd4;

    localparam logic [1:0] CFG_START_PC = 2'd0;
    localparam logic [1:0] CFG_QUIT_PC  = 2'd1;
    localparam logic [1:0] CFG_MEM_BASE = 2'd2;

    typedef enum logic [3:0] {
        K_PRELOAD,
        K_LUI,
        K_AUIPC,
        K_JAL,
        K_JALR,
        K_BRANCH,
        K_LOAD,
        K_STORE,
        K_OPIMM,
        K_OP,
        K_NOP,
        K_BAD
    } kind_t;

    typedef struct packed {
        logic        cmd;
        logic [31:0] instr;
        logic [15:0] preload_offset;
        logic [7:0]  preload_byte;
    } in_word_t;

    typedef struct packed {
        logic [31:0] next_pc;
        logic [4:0]  dest_index;
        logic [31:0] dest_value;
        logic        dest_write;
        logic [2:0]  fault;
        logic        at_end;
    } out_word_t;

    typedef struct packed {
        kind_t       kind;
        logic [2:0]  f3;
        logic        alt;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [31:0] imm;
        logic [15:0] pre_off;
        logic [7:0]  pre_byte;
        logic [2:0]  fault;
    } dec_t;

endpackage
`default_nettype wire

// File: sv/rvx_front.sv
// rvx_front: accepts input words, decodes and classifies them, queues them.
// Depends on rvx_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rvx_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire rvx_pkg::in_word_t item,
    input  wire logic              deq,
    output logic                   dec_valid,
    output rvx_pkg::dec_t          dec
);
    import rvx_pkg::*;

    dec_t       q_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    dec_t       d;
    logic       acc, take;
    logic [31:0] ins;
    logic [2:0]  f3;
    logic [6:0]  f7;

    assign ins = item.instr;
    assign f3  = ins[14:12];
    assign f7  = ins[31:25];

    always_comb
    begin
        d          = '0;
        d.f3       = f3;
        d.alt      = (f7 == F7_ALT);
        d.rd       = ins[11:7];
        d.rs1      = ins[19:15];
        d.rs2      = ins[24:20];
        d.pre_off  = item.preload_offset;
        d.pre_byte = item.preload_byte;
        d.fault    = FAULT_OK;
        d.imm      = {{20{ins[31]}}, ins[31:20]};
        d.kind     = K_BAD;
        if (item.cmd)
        begin
            d.kind = K_PRELOAD;
        end
        else
        begin
            unique case (ins[6:0])
                OPC_LUI:
                begin
                    d.kind = K_LUI;
                    d.imm  = {ins[31:12], 12'b0};
                end
                OPC_AUIPC:
                begin
                    d.kind = K_AUIPC;
                    d.imm  = {ins[31:12], 12'b0};
                end
                OPC_JAL:
                begin
                    d.kind = K_JAL;
                    d.imm  = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
                end
                OPC_JALR:
                begin
                    d.kind = K_JALR;
                    if (f3 != 3'd0) d.fault = FAULT_ILL;
                end
                OPC_BRANCH:
                begin
                    d.kind = K_BRANCH;
                    d.imm  = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
                    if (f3[2:1] == 2'd1) d.fault = FAULT_ILL;
                end
                OPC_LOAD:
                begin
                    d.kind = K_LOAD;
                    if (f3[1:0] == 2'd3 || f3 == 3'd6) d.fault = FAULT_ILL;
                end
                OPC_STORE:
                begin
                    d.kind = K_STORE;
                    d.imm  = {{20{ins[31]}}, ins[31:25], ins[11:7]};
                    if (f3 > 3'd2) d.fault = FAULT_ILL;
                end
                OPC_OPIMM:
                begin
                    d.kind = K_OPIMM;
                    if ((f3 == 3'd1 && f7 != 7'd0)
                        || (f3 == 3'd5 && f7 != 7'd0 && f7 != F7_ALT))
                        d.fault = FAULT_ILL;
                end
                OPC_OP:
                begin
                    d.kind = K_OP;
                    if (f7 != 7'd0 && !((f3 == 3'd0 || f3 == 3'd5) && f7 == F7_ALT))
                        d.fault = FAULT_ILL;
                end
                OPC_FENCE:
                begin
                    d.kind = K_NOP;
                    if (f3 != 3'd0) d.fault = FAULT_ILL;
                end
                OPC_SYSTEM:
                begin
                    d.fault = FAULT_SYS;
                end
                default:
                begin
                    d.fault = FAULT_ILL;
                end
            endcase
            if (d.fault != FAULT_OK) d.kind = K_BAD;
        end
    end

    assign full      = (cnt_reg == 2'd2);
    assign dec_valid = (cnt_reg != 2'd0);
    assign dec       = q_reg[rptr_reg];
    assign acc       = push && !full;
    assign take      = deq && dec_valid;

    always_ff @(posedge clk)
    begin
        if (acc) q_reg[wptr_reg] <= d;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (acc) wptr_reg <= ~wptr_reg;
            if (take) rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + 2'(acc) - 2'(take);
        end
    end

endmodule
`default_nettype wire

// File: sv/rvx_back.sv
// rvx_back: executes decoded words; register file, pc, data window, result queue.
// Depends on rvx_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rvx_back #(
    parameter int DMEM_BYTES = rvx_pkg::DMEM_BYTES_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_we,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [31:0]    cfg_data,
    input  wire logic           dec_valid,
    input  wire rvx_pkg::dec_t  dec,
    output logic                deq,
    output logic                empty,
    input  wire logic           pop,
    output rvx_pkg::out_word_t  result
);
    import rvx_pkg::*;

    localparam int ROWS = (DMEM_BYTES + 3) / 4;
    localparam int RW   = $clog2(ROWS);

    logic [31:0] quit_pc_reg, base_reg, pc_reg;

    // register file
    logic [31:0] rf_reg [32];
    logic [31:0] rf_vld_reg;
    logic [31:0] a_reg, b_reg;
    logic        rf_we;
    logic [4:0]  rf_wa;
    logic [31:0] rf_wd;

    // execute and load stages
    dec_t        ex_reg;
    logic        ex_valid_reg, ld_valid_reg;
    logic [4:0]  ld_rd_reg;
    logic [2:0]  ld_f3_reg;
    logic [1:0]  ld_lane_reg;
    logic [7:0]  ldq_reg [4];

    // data window, four byte lanes; an access may straddle two rows
    logic [7:0]  mem [4][ROWS];
    logic [RW-1:0] m_row [4];
    logic        m_re;
    logic [3:0]  m_we;
    logic [7:0]  m_wd [4];
    logic [1:0]  lj [4];

    // result queue
    out_word_t   oq_reg [2];
    logic        owp_reg, orp_reg;
    logic [1:0]  ocnt_reg;
    logic        space, o_push, o_pop;
    out_word_t   o_word;

    // execute signals
    logic [31:0] opb, alu_res, addr, off, target, new_pc, wval, pc4;
    logic [2:0]  fault;
    logic        wr, taken, win_bad, al_bad, ld_go, ex_done, ld_done, dw;
    logic [32:0] span;
    logic [31:0] pre_off32;
    logic [31:0] ld_val;
    logic [31:0] ld_word;

    assign space   = (ocnt_reg != 2'd2);
    assign ex_done = ex_valid_reg && space;
    assign ld_done = ld_valid_reg && space;
    assign pc4     = pc_reg + 32'd4;
    assign pre_off32 = {16'b0, ex_reg.pre_off};

    always_comb
    begin
        opb = (ex_reg.kind == K_OP) ? b_reg : ex_reg.imm;
        unique case (ex_reg.f3)
            3'd0: alu_res = (ex_reg.kind == K_OP && ex_reg.alt) ? a_reg - opb : a_reg + opb;
            3'd1: alu_res = a_reg << opb[4:0];
            3'd2: alu_res = {31'b0, $signed(a_reg) < $signed(opb)};
            3'd3: alu_res = {31'b0, a_reg < opb};
            3'd4: alu_res = a_reg ^ opb;
            3'd5: alu_res = ex_reg.alt ? 32'($signed(a_reg) >>> opb[4:0]) : a_reg >> opb[4:0];
            3'd6: alu_res = a_reg | opb;
            default: alu_res = a_reg & opb;
        endcase
    end

    always_comb
    begin
        addr    = a_reg + ex_reg.imm;
        off     = addr - base_reg;
        span    = {1'b0, off} + (33'd1 << ex_reg.f3[1:0]);
        win_bad = span > 33'(DMEM_BYTES);
        al_bad  = ex_reg.f3[1] ? (addr[1:0] != 2'd0) : (ex_reg.f3[0] && addr[0]);
        unique case (ex_reg.f3[2:1])
            2'd0: taken = (a_reg == b_reg);
            2'd2: taken = $signed(a_reg) < $signed(b_reg);
            default: taken = (a_reg < b_reg);
        endcase
        taken = taken ^ ex_reg.f3[0];
    end

    always_comb
    begin
        new_pc = pc4;
        fault  = ex_reg.fault;
        wr     = 1'b0;
        wval   = 32'd0;
        target = pc_reg + ex_reg.imm;
        ld_go  = 1'b0;
        m_re   = 1'b0;
        m_we   = 4'b0;
        // lane k holds access byte lj[k], one row further on when it wraps
        for (int k = 0; k < 4; k++)
        begin
            lj[k]    = 2'(k) - off[1:0];
            m_row[k] = off[RW+1:2] + ((2'(k) < off[1:0]) ? RW'(1) : RW'(0));
            m_wd[k]  = b_reg[{lj[k], 3'b000} +: 8];
        end
        unique case (ex_reg.kind)
            K_PRELOAD:
            begin
                new_pc = pc_reg;
                for (int k = 0; k < 4; k++)
                begin
                    m_row[k] = pre_off32[RW+1:2];
                    m_wd[k]  = ex_reg.pre_byte;
                    m_we[k]  = (pre_off32 < 32'(DMEM_BYTES))
                               && (pre_off32[1:0] == 2'(k));
                end
            end
            K_LUI:
            begin
                wr = 1'b1; wval = ex_reg.imm;
            end
            K_AUIPC:
            begin
                wr = 1'b1; wval = pc_reg + ex_reg.imm;
            end
            K_JAL, K_JALR:
            begin
                if (ex_reg.kind == K_JALR) target = addr & 32'hFFFF_FFFE;
                if (target[1:0] != 2'd0) fault = FAULT_ALIGN;
                wr = 1'b1; wval = pc4; new_pc = target;
            end
            K_BRANCH:
            begin
                if (taken)
                begin
                    if (target[1:0] != 2'd0) fault = FAULT_ALIGN;
                    new_pc = target;
                end
            end
            K_LOAD:
            begin
                if (win_bad) fault = FAULT_WINDOW;
                else if (al_bad) fault = FAULT_ALIGN;
                else
                begin
                    ld_go = 1'b1;
                    m_re  = 1'b1;
                end
            end
            K_STORE:
            begin
                if (win_bad) fault = FAULT_WINDOW;
                else if (al_bad) fault = FAULT_ALIGN;
                else
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        m_we[k] = ({1'b0, lj[k]} < (3'd1 << ex_reg.f3[1:0]));
                    end
                end
            end
            K_OPIMM, K_OP:
            begin
                wr = 1'b1; wval = alu_res;
            end
            default:
            begin
                wr = 1'b0;
            end
        endcase
        if (fault != FAULT_OK)
        begin
            new_pc = pc_reg;
            wr     = 1'b0;
            ld_go  = 1'b0;
            m_re   = 1'b0;
            m_we   = 4'b0;
        end
        if (!ex_done)
        begin
            m_re = 1'b0;
            m_we = 4'b0;
        end
        dw = wr && (ex_reg.rd != 5'd0);
    end

    // load formatting: byte i of the access sits in lane (first lane + i)
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            ld_word[8*i +: 8] = ldq_reg[ld_lane_reg + 2'(i)];
        end
        unique case (ld_f3_reg[1:0])
            2'd0:
            begin
                ld_val = ld_f3_reg[2] ? {24'b0, ld_word[7:0]}
                                      : {{24{ld_word[7]}}, ld_word[7:0]};
            end
            2'd1:
            begin
                ld_val = ld_f3_reg[2] ? {16'b0, ld_word[15:0]}
                                      : {{16{ld_word[15]}}, ld_word[15:0]};
            end
            default: ld_val = ld_word;
        endcase
    end

    // register file write port and result word
    always_comb
    begin
        o_word = '0;
        rf_we  = 1'b0;
        rf_wa  = ex_reg.rd;
        rf_wd  = wval;
        o_push = 1'b0;
        if (ld_done)
        begin
            o_push            = 1'b1;
            rf_we             = (ld_rd_reg != 5'd0);
            rf_wa             = ld_rd_reg;
            rf_wd             = ld_val;
            o_word.next_pc    = pc_reg;
            o_word.dest_write = rf_we;
            o_word.dest_index = rf_we ? ld_rd_reg : 5'd0;
            o_word.dest_value = rf_we ? ld_val : 32'd0;
            o_word.fault      = FAULT_OK;
            o_word.at_end     = (pc_reg == quit_pc_reg);
        end
        else if (ex_done)
        begin
            rf_we             = dw && !ld_go;
            o_push            = !ld_go;
            o_word.next_pc    = new_pc;
            o_word.dest_write = dw;
            o_word.dest_index = dw ? ex_reg.rd : 5'd0;
            o_word.dest_value = dw ? wval : 32'd0;
            o_word.fault      = fault;
            o_word.at_end     = (new_pc == quit_pc_reg);
        end
    end

    assign deq = dec_valid && (!ex_valid_reg || (ex_done && !ld_go))
                 && (!ld_valid_reg || ld_done);

    always_ff @(posedge clk)
    begin
        if (rf_we) rf_reg[rf_wa] <= rf_wd;
        if (deq)
        begin
            ex_reg <= dec;
            a_reg  <= (rf_we && rf_wa == dec.rs1) ? rf_wd
                      : (rf_vld_reg[dec.rs1] ? rf_reg[dec.rs1] : 32'd0);
            b_reg  <= (rf_we && rf_wa == dec.rs2) ? rf_wd
                      : (rf_vld_reg[dec.rs2] ? rf_reg[dec.rs2] : 32'd0);
        end
        if (ex_done && ld_go)
        begin
            ld_rd_reg   <= ex_reg.rd;
            ld_f3_reg   <= ex_reg.f3;
            ld_lane_reg <= off[1:0];
        end
        if (o_push) oq_reg[owp_reg] <= o_word;
    end

    for (genvar k = 0; k < 4; k++)
    begin : g_lane
        always_ff @(posedge clk)
        begin
            if (m_we[k]) mem[k][m_row[k]] <= m_wd[k];
            if (m_re) ldq_reg[k] <= mem[k][m_row[k]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quit_pc_reg  <= 32'h0001_0000;
            base_reg     <= 32'd0;
            pc_reg       <= 32'd0;
            rf_vld_reg   <= 32'd0;
            ex_valid_reg <= 1'b0;
            ld_valid_reg <= 1'b0;
            owp_reg      <= 1'b0;
            orp_reg      <= 1'b0;
            ocnt_reg     <= 2'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_QUIT_PC:  quit_pc_reg <= cfg_data;
                    CFG_MEM_BASE: base_reg    <= cfg_data;
                    default:      base_reg    <= base_reg;
                endcase
            end
            if (cfg_we && cfg_index == CFG_START_PC) pc_reg <= cfg_data;
            else if (ex_done) pc_reg <= ld_go ? pc4 : new_pc;
            if (rf_we) rf_vld_reg[rf_wa] <= 1'b1;
            if (deq) ex_valid_reg <= 1'b1;
            else if (ex_done) ex_valid_reg <= 1'b0;
            if (ex_done && ld_go) ld_valid_reg <= 1'b1;
            else if (ld_done) ld_valid_reg <= 1'b0;
            if (o_push) owp_reg <= ~owp_reg;
            if (o_pop) orp_reg <= ~orp_reg;
            ocnt_reg <= ocnt_reg + 2'(o_push) - 2'(o_pop);
        end
    end

    assign empty  = (ocnt_reg == 2'd0);
    assign o_pop  = pop && !empty;
    assign result = oq_reg[orp_reg];

    a_ld_ex_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ld_valid_reg && ex_valid_reg))
        else $error("load stage and execute stage both busy");
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        o_push |-> ocnt_reg != 2'd2)
        else $error("result queue overfilled");
    a_fault_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (o_push && o_word.fault != FAULT_OK) |-> !o_word.dest_write && !rf_we)
        else $error("register write on faulting word");
    a_load_holds_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (ex_done && ld_go) |=> !$past(deq) && ld_valid_reg)
        else $error("issue during pending load");
    a_x0_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rf_we |-> rf_wa != 5'd0)
        else $error("write to x0");

endmodule
`default_nettype wire

// File: sv/rv32i_instruction_executor_core.sv
// RV32I executor top: decode queue in front, execute/memory back end behind it.
// Throughput: one word per cycle while the result queue has space and no load is pending;
// a load holds the back end until it completes
// (one synchronous data window read, then register write).
// Reset: asynchronous, clears queues, registers read zero, pc = 0 (start_pc is set by a config write).
// Depends on rvx_pkg, rvx_front, rvx_back.
`timescale 1ns / 1ps
`default_nettype none
module rv32i_instruction_executor_core #(
    parameter int DMEM_BYTES = rvx_pkg::DMEM_BYTES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire rvx_pkg::in_word_t  item,
    output logic                    empty,
    input  wire logic               pop,
    output rvx_pkg::out_word_t      result,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);
    import rvx_pkg::*;

    dec_t dec;
    logic dec_valid, deq;

    rvx_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .deq       (deq),
        .dec_valid (dec_valid),
        .dec       (dec)
    );

    rvx_back #(
        .DMEM_BYTES (DMEM_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .dec_valid (dec_valid),
        .dec       (dec),
        .deq       (deq),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule
`default_nettype wire

// File: dv/testbench.sv
// Testbench for rv32i_instruction_executor_core: directed and random RV32I words,
// checked against an in-bench executor model with its own registers, pc and data window.
// Depends on rvx_pkg and the core RTL.
`timescale 1ns / 1ps
module testbench;
    import rvx_pkg::*;

    localparam int WIN = 65536;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    in_word_t item = '0;
    logic empty;
    logic pop = 1'b0;
    out_word_t result;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = CFG_START_PC;
    logic [31:0] cfg_data = '0;

    rv32i_instruction_executor_core dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .item(item),
        .empty(empty), .pop(pop), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // executor model state
    logic [31:0] gpr [32];
    logic [31:0] pc_q, quit_q, base_q;
    logic [7:0] win_mem [WIN];
    bit win_known [WIN];
    out_word_t expected_q [$];
    int errors = 0;
    bit hold = 1'b0;
    bit calm = 1'b0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    function automatic logic [2:0] window_fault(input logic [31:0] addr, input int n);
        logic [31:0] off;
        off = addr - base_q;
        if ({32'b0, off} + n > WIN)
            return FAULT_WINDOW;
        if ((addr & (n - 1)) != 0)
            return FAULT_ALIGN;
        return FAULT_OK;
    endfunction

    function automatic logic [2:0] alu_op(input logic [2:0] f3, input logic [6:0] f7,
                                         input logic [31:0] a, input logic [31:0] b,
                                         input bit reg_form, output logic [31:0] res);
        bit sub_ok;
        sub_ok = reg_form && f3 == 3'd0;
        res = '0;
        if ((f3 == 3'd1 || f3 == 3'd5 || reg_form) && f7 != 7'd0
                && !((f3 == 3'd5 || sub_ok) && f7 == F7_ALT))
            return FAULT_ILL;
        case (f3)
            3'd0: res = (sub_ok && f7 == F7_ALT) ? a - b : a + b;
            3'd1: res = a << b[4:0];
            3'd2: res = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            3'd3: res = (a < b) ? 32'd1 : 32'd0;
            3'd4: res = a ^ b;
            3'd5: res = (f7 == F7_ALT) ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
            3'd6: res = a | b;
            default: res = a & b;
        endcase
        return FAULT_OK;
    endfunction

    task automatic execute_word(input in_word_t w);
        out_word_t r;
        logic [31:0] ins, a, b, imm_i, imm_s, imm_b, imm_j, tgt, npc, val, addr, off;
        logic [6:0] opc;
        logic [2:0] f3, flt;
        logic [4:0] rd;
        bit wr, taken;
        int n;
        npc = pc_q;
        flt = FAULT_OK;
        wr = 0;
        val = '0;
        rd = '0;
        if (w.cmd) begin
            win_mem[w.preload_offset] = w.preload_byte;
            win_known[w.preload_offset] = 1'b1;
        end else begin
            ins = w.instr;
            opc = ins[6:0];
            f3 = ins[14:12];
            a = gpr[ins[19:15]];
            b = gpr[ins[24:20]];
            imm_i = {{20{ins[31]}}, ins[31:20]};
            imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
            imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
            imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
            rd = ins[11:7];
            npc = pc_q + 32'd4;
            case (opc)
                OPC_LUI: begin wr = 1; val = {ins[31:12], 12'b0}; end
                OPC_AUIPC: begin wr = 1; val = pc_q + {ins[31:12], 12'b0}; end
                OPC_JAL, OPC_JALR: begin
                    if (opc == OPC_JALR && f3 != 3'd0)
                        flt = FAULT_ILL;
                    else begin
                        tgt = (opc == OPC_JAL) ? pc_q + imm_j : ((a + imm_i) & ~32'd1);
                        if (tgt[1:0] != 2'b0)
                            flt = FAULT_ALIGN;
                        else begin
                            wr = 1;
                            val = pc_q + 32'd4;
                            npc = tgt;
                        end
                    end
                end
                OPC_BRANCH: begin
                    if (f3[2:1] == 2'd1)
                        flt = FAULT_ILL;
                    else begin
                        if (f3[2:1] == 2'd0) taken = (a == b);
                        else if (f3[2:1] == 2'd2) taken = $signed(a) < $signed(b);
                        else taken = a < b;
                        if (f3[0]) taken = !taken;
                        if (taken) begin
                            tgt = pc_q + imm_b;
                            if (tgt[1:0] != 2'b0) flt = FAULT_ALIGN;
                            else npc = tgt;
                        end
                    end
                end
                OPC_LOAD: begin
                    if (f3[1:0] == 2'd3 || f3 == 3'd6)
                        flt = FAULT_ILL;
                    else begin
                        n = 1 << f3[1:0];
                        addr = a + imm_i;
                        flt = window_fault(addr, n);
                        if (flt == FAULT_OK) begin
                            off = addr - base_q;
                            for (int i = 0; i < n; i++)
                                val[8*i +: 8] = win_mem[int'(off) + i];
                            if (f3 == 3'd0) val = {{24{val[7]}}, val[7:0]};
                            if (f3 == 3'd1) val = {{16{val[15]}}, val[15:0]};
                            wr = 1;
                        end
                    end
                end
                OPC_STORE: begin
                    if (f3 > 3'd2)
                        flt = FAULT_ILL;
                    else begin
                        n = 1 << f3;
                        addr = a + imm_s;
                        flt = window_fault(addr, n);
                        if (flt == FAULT_OK) begin
                            off = addr - base_q;
                            for (int i = 0; i < n; i++) begin
                                win_mem[int'(off) + i] = b[8*i +: 8];
                                win_known[int'(off) + i] = 1'b1;
                            end
                        end
                    end
                end
                OPC_OPIMM: begin
                    flt = alu_op(f3, ins[31:25], a,
                                 (f3 == 3'd1 || f3 == 3'd5) ? {27'b0, ins[24:20]} : imm_i,
                                 1'b0, val);
                    wr = (flt == FAULT_OK);
                end
                OPC_OP: begin
                    flt = alu_op(f3, ins[31:25], a, b, 1'b1, val);
                    wr = (flt == FAULT_OK);
                end
                OPC_FENCE: if (f3 != 3'd0) flt = FAULT_ILL;
                OPC_SYSTEM: flt = FAULT_SYS;
                default: flt = FAULT_ILL;
            endcase
            if (flt != FAULT_OK) begin
                npc = pc_q;
                wr = 0;
            end
        end
        if (wr && rd != 5'd0)
            gpr[rd] = val;
        else begin
            wr = 0;
            rd = '0;
            val = '0;
        end
        pc_q = npc;
        r.next_pc = npc;
        r.dest_index = rd;
        r.dest_value = val;
        r.dest_write = wr;
        r.fault = flt;
        r.at_end = (npc == quit_q);
        expected_q.push_back(r);
    endtask

    // result checker
    always @(posedge clk) begin
        if (rst_n && pop && !empty) begin
            if (expected_q.size() == 0) begin
                report("unexpected word", result.next_pc, 32'd0);
            end else begin
                out_word_t e;
                e = expected_q.pop_front();
                if (result.next_pc !== e.next_pc) report("next_pc", result.next_pc, e.next_pc);
                if (result.dest_index !== e.dest_index)
                    report("dest_index", 32'(result.dest_index), 32'(e.dest_index));
                if (result.dest_value !== e.dest_value)
                    report("dest_value", result.dest_value, e.dest_value);
                if (result.dest_write !== e.dest_write)
                    report("dest_write", 32'(result.dest_write), 32'(e.dest_write));
                if (result.fault !== e.fault)
                    report("fault", 32'(result.fault), 32'(e.fault));
                if (result.at_end !== e.at_end)
                    report("at_end", 32'(result.at_end), 32'(e.at_end));
            end
        end
    end

    always @(negedge clk)
        pop <= rst_n && !hold && (calm || $urandom_range(99) >= 34);

    task automatic send_word(input in_word_t w);
        if (!calm && $urandom_range(99) < 34) begin
            @(negedge clk);
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end else
            @(negedge clk);
        push <= 1'b1;
        item <= w;
        @(posedge clk);
        while (full) @(posedge clk);
        execute_word(w);
    endtask

    task automatic preload(input logic [15:0] off, input logic [7:0] val);
        in_word_t w;
        w.cmd = 1'b1;
        w.instr = $urandom;
        w.preload_offset = off;
        w.preload_byte = val;
        send_word(w);
    endtask

    // loads must never touch a byte that nothing has written yet
    task automatic issue(input logic [31:0] ins);
        in_word_t w;
        logic [31:0] off;
        int n;
        if (ins[6:0] == OPC_LOAD && ins[13:12] != 2'd3 && ins[14:12] != 3'd6) begin
            n = 1 << ins[13:12];
            off = gpr[ins[19:15]] + {{20{ins[31]}}, ins[31:20]};
            if (window_fault(off, n) == FAULT_OK) begin
                off = off - base_q;
                for (int i = 0; i < n; i++)
                    if (!win_known[int'(off) + i])
                        preload(16'(int'(off) + i), 8'($urandom));
            end
        end
        w.cmd = 1'b0;
        w.instr = ins;
        w.preload_offset = 16'($urandom);
        w.preload_byte = 8'($urandom);
        send_word(w);
    endtask

    function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3,
                                          input logic [4:0] rd, input logic [6:0] opc);
        return {f7, rs2, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
                                          input logic [2:0] f3, input logic [4:0] rd,
                                          input logic [6:0] opc);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_b(input logic [12:0] imm, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
    endfunction

    function automatic logic [31:0] enc_j(input logic [20:0] imm, input logic [4:0] rd);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
    endfunction

    // LUI a base into a register, then the access relative to it
    task automatic mem_access(input bit is_store, input logic [2:0] f3,
                              input logic [31:0] off);
        logic [31:0] addr, hi, lo;
        logic [4:0] rs;
        addr = base_q + off;
        hi = (addr + 32'h800) & 32'hFFFFF000;
        lo = addr - hi;
        rs = 5'($urandom_range(1, 31));
        issue({hi[31:12], rs, OPC_LUI});
        if (is_store)
            issue({lo[11:5], 5'($urandom), rs, f3, lo[4:0], OPC_STORE});
        else
            issue(enc_i(lo[11:0], rs, f3, 5'($urandom), OPC_LOAD));
    endtask

    function automatic logic [31:0] pick_offset();
        case ($urandom_range(9))
            0: return 32'(WIN - 4 + $urandom_range(0, 6));
            1: return $urandom;
            2: return -32'($urandom_range(1, 4));
            default: return $urandom_range(0, 63);
        endcase
    endfunction

    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [31:0] val);
        drain();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_START_PC: pc_q = val;
            CFG_QUIT_PC: quit_q = val;
            default: base_q = val;
        endcase
    endtask

    task automatic random_step();
        logic [2:0] f3;
        logic [6:0] f7;
        int k;
        k = $urandom_range(99);
        f3 = 3'($urandom);
        case ($urandom_range(3))
            0: f7 = 7'd0;
            1: f7 = F7_ALT;
            2: f7 = 7'($urandom);
            default: f7 = 7'd0;
        endcase
        if (k < 8)
            issue($urandom);
        else if (k < 14)
            preload(16'($urandom), 8'($urandom));
        else if (k < 38)
            issue(enc_r(f7, 5'($urandom), 5'($urandom), f3, 5'($urandom), OPC_OPIMM));
        else if (k < 58)
            issue(enc_r(f7, 5'($urandom), 5'($urandom), f3, 5'($urandom), OPC_OP));
        else if (k < 64)
            issue({20'($urandom), 5'($urandom), ($urandom_range(1)) ? OPC_LUI : OPC_AUIPC});
        else if (k < 74)
            issue(enc_b({11'($urandom), ($urandom_range(4) == 0) ? 2'b10 : 2'b00},
                        5'($urandom), 5'($urandom), f3));
        else if (k < 80)
            issue(enc_j({19'($urandom), ($urandom_range(4) == 0) ? 2'b10 : 2'b00},
                        5'($urandom)));
        else if (k < 84)
            issue(enc_i(12'($urandom), 5'($urandom), ($urandom_range(5) == 0) ? f3 : 3'd0,
                        5'($urandom), OPC_JALR));
        else if (k < 97)
            mem_access(1'($urandom_range(1)), f3, pick_offset());
        else
            issue(enc_i(12'($urandom), 5'($urandom), ($urandom_range(2) == 0) ? f3 : 3'd0,
                        5'($urandom), ($urandom_range(1)) ? OPC_FENCE : OPC_SYSTEM));
    endtask

    task automatic test_each_operation();
        issue({20'hFFFFF, 5'd1, OPC_LUI});
        issue({20'hABCDE, 5'd0, OPC_LUI});
        issue({20'h80000, 5'd2, OPC_AUIPC});
        issue(enc_i(12'h800, 5'd0, 3'd0, 5'd3, OPC_OPIMM));
        issue(enc_i(12'h7FF, 5'd0, 3'd0, 5'd4, OPC_OPIMM));
        issue(enc_r(F7_ALT, 5'd4, 5'd3, 3'd0, 5'd5, OPC_OP));
        issue(enc_r(F7_ALT, 5'd31, 5'd1, 3'd5, 5'd6, OPC_OPIMM));
        issue(enc_r(F7_ALT, 5'd4, 5'd1, 3'd1, 5'd7, OPC_OPIMM));
        issue(enc_r(7'd0, 5'd4, 5'd3, 3'd2, 5'd8, OPC_OP));
        issue(enc_r(7'd0, 5'd4, 5'd3, 3'd3, 5'd9, OPC_OP));
        issue(enc_r(F7_ALT, 5'd4, 5'd3, 3'd4, 5'd9, OPC_OP));
        preload(16'hFFFF, 8'h80);
        mem_access(1'b1, 3'd2, 32'd4);
        mem_access(1'b0, 3'd2, 32'd4);
        mem_access(1'b0, 3'd0, 32'(WIN - 1));
        mem_access(1'b0, 3'd1, 32'd1);
        mem_access(1'b0, 3'd2, 32'(WIN - 2));
        mem_access(1'b1, 3'd3, 32'd0);
        issue(enc_i(12'h0, 5'd0, 3'd3, 5'd10, OPC_LOAD));
        issue(enc_b(13'd8, 5'd0, 5'd0, 3'd0));
        issue(enc_b(13'd6, 5'd0, 5'd1, 3'd1));
        issue(enc_b(13'd8, 5'd0, 5'd0, 3'd2));
        issue(enc_j(21'h1FFFF4, 5'd11));
        issue(enc_j(21'd2, 5'd11));
        issue(enc_i(12'h41, 5'd0, 3'd0, 5'd12, OPC_JALR));
        issue(enc_i(12'h40, 5'd0, 3'd1, 5'd12, OPC_JALR));
        issue(enc_i(12'h0, 5'd0, 3'd0, 5'd0, OPC_FENCE));
        issue(enc_i(12'h0, 5'd0, 3'd1, 5'd0, OPC_FENCE));
        issue(enc_i(12'h0, 5'd0, 3'd0, 5'd0, OPC_SYSTEM));
        issue(32'h0000_0000);
    endtask

    task automatic test_config_extremes();
        write_cfg(CFG_START_PC, 32'hFFFF_FFF8);
        write_cfg(CFG_QUIT_PC, 32'hFFFF_FFFC);
        write_cfg(CFG_MEM_BASE, 32'hFFFF_FFFF);
        repeat (40) random_step();
        write_cfg(CFG_START_PC, 32'h0);
        write_cfg(CFG_QUIT_PC, 32'h0);
        write_cfg(CFG_MEM_BASE, 32'hFFFF_8000);
        repeat (40) random_step();
        write_cfg(CFG_QUIT_PC, 32'hFFFF_FFFF);
        write_cfg(CFG_MEM_BASE, 32'h0);
        repeat (40) random_step();
    endtask

    task automatic test_random_programs();
        logic [31:0] sp;
        for (int ph = 0; ph < 5; ph++) begin
            sp = {$urandom_range(1) ? 30'($urandom) : 30'd0, 2'b00};
            write_cfg(CFG_START_PC, sp);
            write_cfg(CFG_QUIT_PC, sp + 32'(4 * $urandom_range(0, 8)));
            write_cfg(CFG_MEM_BASE, $urandom_range(1) ? $urandom : 32'h0);
            calm = (ph == 2);
            repeat (200) random_step();
            calm = 1'b0;
        end
    endtask

    task automatic test_backpressure();
        hold = 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                hold = 1'b0;
            end
        join_none
        repeat (60) random_step();
    endtask

    initial begin
        for (int i = 0; i < 32; i++) gpr[i] = '0;
        for (int i = 0; i < WIN; i++) win_known[i] = 1'b0;
        pc_q = '0;
        quit_q = 32'h0001_0000;
        base_q = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_each_operation();
        test_config_extremes();
        test_backpressure();
        test_random_programs();
        drain();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end

endmodule

// File: files.f
sv/rvx_pkg.sv
sv/rvx_front.sv
sv/rvx_back.sv
sv/rv32i_instruction_executor_core.sv
dv/testbench.sv
